[design/wss_pkg.sv]
// ----------------------------------------------------------------------------
// WAV sample converter package
// Codes, register indexes and widths shared by the channel interfaces and
// the converter.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned SAMPLE_W   = 64;
  localparam int unsigned PCM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CODEC_W    = 16;
  localparam int unsigned BPS_W      = 7;

  localparam logic [CODEC_W-1:0] CODEC_PCM   = 16'h0001;
  localparam logic [CODEC_W-1:0] CODEC_FLOAT = 16'h0003;

  localparam logic [CFG_IDX_W-1:0] REG_CODEC_TAG = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPS       = 8'd1;

  localparam logic [CODEC_W-1:0] CODEC_RST = CODEC_PCM;
  localparam logic [BPS_W-1:0]   BPS_RST   = 7'd16;

endpackage

[design/wss_if.sv]
// ----------------------------------------------------------------------------
// WAV sample converter channels
// Valid/ready channels for raw samples, converted samples and register writes.
// ----------------------------------------------------------------------------
interface wss_in_if;
  logic                         valid;
  logic                         ready;
  logic [wss_pkg::SAMPLE_W-1:0] sample_bytes;

  modport source (output valid, output sample_bytes, input ready);
  modport sink   (input valid, input sample_bytes, output ready);
endinterface

interface wss_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wss_pkg::PCM_W-1:0] pcm_out;
  logic                             unsupported;

  modport source (output valid, output pcm_out, output unsupported, input ready);
  modport sink   (input valid, input pcm_out, input unsupported, output ready);
endinterface

interface wss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wss_pkg::CFG_IDX_W-1:0]  index;
  logic [wss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/wav_sample_to_s16_converter.sv]
// ----------------------------------------------------------------------------
// WAV sample to signed 16-bit converter
// Five-stage pipeline turning one raw PCM or IEEE float sample into s16.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : raw little-endian sample, first file byte in bits 7:0.
//   out_ch : converted sample and an unsupported flag (sample 0 when set).
//   cfg_ch : register writes, index 0 codec tag, index 1 bits per sample;
//            always ready. Write only while the pipeline is empty.
// Five register stages, the first loaded by the input transfer itself. One
// sample is accepted per cycle while the output is not stalled; the stages
// are decode, x32767 product, round to double, alignment shift, then
// saturate/negate into the output register.
// Each stage has its own valid bit and loads when it is empty or its
// successor is loading, so a stalled output only holds up the stages behind
// it that are full; bubbles are squeezed out.
// Reset (rst_n low, synchronous) empties the pipeline and sets the codec to
// PCM at 16 bits.
// ----------------------------------------------------------------------------
module wav_sample_to_s16_converter (
  input logic       clk,
  input logic       rst_n,
  wss_in_if.sink    in_ch,
  wss_out_if.source out_ch,
  wss_cfg_if.sink   cfg_ch
);
  import wss_pkg::*;

  // configuration
  logic [CODEC_W-1:0] codec_r;
  logic [BPS_W-1:0]   bps_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= CODEC_RST;
      bps_r   <= BPS_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_CODEC_TAG) begin
        codec_r <= cfg_ch.data[CODEC_W-1:0];
      end else if (cfg_ch.index == REG_BPS) begin
        bps_r <= cfg_ch.data[BPS_W-1:0];
      end
    end
  end

  // stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5 = !v5_r || out_ch.ready;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_ch.ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_ch.valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
    end
  end

  // ---------------- stage 1: decode ----------------
  logic               bad_nxt, flt_nxt, zero_nxt, sign_nxt;
  logic [PCM_W-1:0]   pcm_nxt;
  logic signed [12:0] exp_nxt;
  logic [52:0]        man_nxt;

  always_comb begin
    logic [SAMPLE_W-1:0] s;
    s        = in_ch.sample_bytes;
    bad_nxt  = 1'b1;
    flt_nxt  = 1'b0;
    pcm_nxt  = '0;
    zero_nxt = 1'b0;
    sign_nxt = 1'b0;
    exp_nxt  = '0;
    man_nxt  = '0;
    if (codec_r == CODEC_PCM) begin
      case (bps_r)
        7'd8: begin
          bad_nxt = 1'b0;
          pcm_nxt = {s[7:0] + 8'h80, 8'h00};
        end
        7'd16: begin
          bad_nxt = 1'b0;
          pcm_nxt = s[15:0];
        end
        7'd24: begin
          bad_nxt = 1'b0;
          pcm_nxt = s[23:8];
        end
        7'd32: begin
          bad_nxt = 1'b0;
          pcm_nxt = s[31:16];
        end
        default: bad_nxt = 1'b1;
      endcase
    end else if (codec_r == CODEC_FLOAT) begin
      case (bps_r)
        7'd32: begin
          bad_nxt  = 1'b0;
          flt_nxt  = 1'b1;
          sign_nxt = s[31];
          // NaN/inf give 0; zero and denormals are far below half an LSB
          zero_nxt = (s[30:23] == 8'hFF) || (s[30:23] == 8'h00);
          exp_nxt  = $signed({5'd0, s[30:23]}) - 13'sd127;
          man_nxt  = {1'b1, s[22:0], 29'd0};
        end
        7'd64: begin
          bad_nxt  = 1'b0;
          flt_nxt  = 1'b1;
          sign_nxt = s[63];
          zero_nxt = (s[62:52] == 11'h7FF) || (s[62:52] == 11'h000);
          exp_nxt  = $signed({2'd0, s[62:52]}) - 13'sd1023;
          man_nxt  = {1'b1, s[51:0]};
        end
        default: bad_nxt = 1'b1;
      endcase
    end
  end

  logic               s1_bad_r, s1_flt_r, s1_zero_r, s1_sign_r;
  logic [PCM_W-1:0]   s1_pcm_r;
  logic signed [12:0] s1_exp_r;
  logic [52:0]        s1_man_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_bad_r  <= bad_nxt;
      s1_flt_r  <= flt_nxt;
      s1_zero_r <= zero_nxt;
      s1_sign_r <= sign_nxt;
      s1_pcm_r  <= pcm_nxt;
      s1_exp_r  <= exp_nxt;
      s1_man_r  <= man_nxt;
    end
  end

  // ---------------- stage 2: mantissa x 32767 ----------------
  logic               s2_bad_r, s2_flt_r, s2_zero_r, s2_sign_r;
  logic [PCM_W-1:0]   s2_pcm_r;
  logic signed [12:0] s2_exp_r;
  logic [67:0]        s2_prod_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_bad_r  <= s1_bad_r;
      s2_flt_r  <= s1_flt_r;
      s2_zero_r <= s1_zero_r;
      s2_sign_r <= s1_sign_r;
      s2_pcm_r  <= s1_pcm_r;
      s2_exp_r  <= s1_exp_r - 13'sd52;
      s2_prod_r <= {s1_man_r, 15'd0} - {15'd0, s1_man_r};
    end
  end

  // ---------------- stage 3: round product to 53 bits (RNE) ----------------
  logic [53:0]        q_nxt;
  logic signed [12:0] x_nxt;

  always_comb begin
    logic [52:0] q0;
    logic        g, st;
    if (s2_prod_r[67]) begin
      q0    = s2_prod_r[67:15];
      g     = s2_prod_r[14];
      st    = |s2_prod_r[13:0];
      x_nxt = s2_exp_r + 13'sd15;
    end else begin
      q0    = s2_prod_r[66:14];
      g     = s2_prod_r[13];
      st    = |s2_prod_r[12:0];
      x_nxt = s2_exp_r + 13'sd14;
    end
    q_nxt = {1'b0, q0} + {53'd0, g & (st | q0[0])};
  end

  logic               s3_bad_r, s3_flt_r, s3_zero_r, s3_sign_r;
  logic [PCM_W-1:0]   s3_pcm_r;
  logic signed [12:0] s3_x_r;
  logic [53:0]        s3_q_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_bad_r  <= s2_bad_r;
      s3_flt_r  <= s2_flt_r;
      s3_zero_r <= s2_zero_r;
      s3_sign_r <= s2_sign_r;
      s3_pcm_r  <= s2_pcm_r;
      s3_x_r    <= x_nxt;
      s3_q_r    <= q_nxt;
    end
  end

  // ---------------- stage 4: align to one fraction bit ----------------
  // value = q * 2^x with q in [2^52, 2^53]; x >= -36 is at least 2^16,
  // x <= -55 is below one half
  logic        sat_nxt;
  logic [17:0] h_nxt;

  always_comb begin
    logic [53:0]        sh;
    logic signed [12:0] amt;
    sat_nxt = 1'b0;
    h_nxt   = '0;
    amt     = -s3_x_r - 13'sd1;
    sh      = s3_q_r >> amt[5:0];
    if (s3_x_r >= -13'sd36) begin
      sat_nxt = 1'b1;
    end else if (s3_x_r > -13'sd55) begin
      h_nxt = sh[17:0];
    end
  end

  logic             s4_bad_r, s4_flt_r, s4_zero_r, s4_sign_r, s4_sat_r;
  logic [PCM_W-1:0] s4_pcm_r;
  logic [17:0]      s4_h_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_bad_r  <= s3_bad_r;
      s4_flt_r  <= s3_flt_r;
      s4_zero_r <= s3_zero_r;
      s4_sign_r <= s3_sign_r;
      s4_sat_r  <= sat_nxt;
      s4_pcm_r  <= s3_pcm_r;
      s4_h_r    <= h_nxt;
    end
  end

  // ---------------- stage 5: round half away, saturate, sign ----------------
  logic [PCM_W-1:0] res_nxt;

  always_comb begin
    logic [18:0] r;
    r = ({1'b0, s4_h_r} + 19'd1) >> 1;
    if (s4_bad_r) begin
      res_nxt = '0;
    end else if (!s4_flt_r) begin
      res_nxt = s4_pcm_r;
    end else if (s4_zero_r) begin
      res_nxt = '0;
    end else if (s4_sign_r) begin
      res_nxt = (s4_sat_r || r >= 19'd32768) ? 16'h8000 : 16'(-r[15:0]);
    end else begin
      res_nxt = (s4_sat_r || r >= 19'd32767) ? 16'h7FFF : r[15:0];
    end
  end

  logic [PCM_W-1:0] pcm_out_r;
  logic             unsup_r;

  always_ff @(posedge clk) begin
    if (ld5) begin
      pcm_out_r <= res_nxt;
      unsup_r   <= s4_bad_r;
    end
  end

  assign out_ch.valid       = v5_r;
  assign out_ch.pcm_out     = pcm_out_r;
  assign out_ch.unsupported = unsup_r;

  // ---------------- assertions ----------------
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && unsup_r |-> pcm_out_r == '0)
    else $error("unsupported result with non-zero sample");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v5_r |-> in_ch.ready)
    else $error("empty output stage but input not ready");

  a_hold_s4: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !ld4 |=> v4_r)
    else $error("stalled item dropped from stage 4");

  a_flt_pcm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && s1_flt_r |-> !s1_bad_r)
    else $error("float item flagged unsupported");

endmodule

[tb/wss_conv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV sample converter checker
// Watches the sample, result and register channels of the converter, keeps
// its own copy of the codec and depth registers, predicts each converted
// sample and compares it with the results in order of transfer.
// ----------------------------------------------------------------------------
module wss_conv_checker (
  input  logic clk,
  input  logic rst_n,
  wss_in_if    in_ch,
  wss_out_if   out_ch,
  wss_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import wss_pkg::*;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    unsupported;
  } s16_result_t;

  s16_result_t        expected_q[$];
  logic [CODEC_W-1:0] codec_tag;
  logic [BPS_W-1:0]   depth;

  initial fail_count = 0;

  function automatic logic signed [15:0] scale_s16(input real v);
    real p;
    real frac;
    int  t;
    p = v * 32767.0;
    if (p >= 32766.5) return 16'sh7fff;
    if (p <= -32767.5) return 16'sh8000;
    t = $rtoi(p);
    frac = p - t;
    if (frac >= 0.5) t++;
    else if (frac <= -0.5) t--;
    return t[15:0];
  endfunction

  function automatic s16_result_t convert_sample(input logic [63:0] s);
    s16_result_t r;
    logic [63:0] dbits;
    r = '0;
    if (codec_tag == CODEC_PCM) begin
      case (depth)
        7'd8:    r.pcm = {s[7:0] + 8'h80, 8'h00};
        7'd16:   r.pcm = s[15:0];
        7'd24:   r.pcm = s[23:8];
        7'd32:   r.pcm = s[31:16];
        default: r.unsupported = 1'b1;
      endcase
    end else if (codec_tag == CODEC_FLOAT) begin
      if (depth == 7'd32) begin
        // zero and subnormals scale to well under half an LSB
        if (s[30:23] != 8'hff && s[30:23] != 8'h00) begin
          dbits = {s[31], 11'(s[30:23]) + 11'd896, s[22:0], 29'd0};
          r.pcm = scale_s16($bitstoreal(dbits));
        end
      end else if (depth == 7'd64) begin
        if (s[62:52] != 11'h7ff) r.pcm = scale_s16($bitstoreal(s));
      end else begin
        r.unsupported = 1'b1;
      end
    end else begin
      r.unsupported = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    s16_result_t want;
    if (!rst_n) begin
      codec_tag <= CODEC_RST;
      depth     <= BPS_RST;
      expected_q.delete();
      pending   <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_CODEC_TAG) codec_tag <= cfg_ch.data;
        else if (cfg_ch.index == REG_BPS) depth <= cfg_ch.data[BPS_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer", out_ch.pcm_out, 16'h0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.pcm_out !== want.pcm)
            report("pcm_out", out_ch.pcm_out, want.pcm);
          if (out_ch.unsupported !== want.unsupported)
            report("unsupported", 16'(out_ch.unsupported), 16'(want.unsupported));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(convert_sample(in_ch.sample_bytes));
      pending <= expected_q.size();
    end
  end

endmodule

[tb/wav_sample_to_s16_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV sample converter testbench
// Drives directed and random samples through every supported codec and depth
// setting and some unsupported ones, with random idling on both channels, and
// gives the verdict from the checker's count of mismatches or a stall watchdog.
// ----------------------------------------------------------------------------
module wav_sample_to_s16_converter_tb;
  import wss_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   in_idle  = 0;
  int   out_idle = 0;
  int   stall_cycles = 0;

  wss_in_if  in_ch();
  wss_out_if out_ch();
  wss_cfg_if cfg_ch();

  wav_sample_to_s16_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wss_conv_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.sample_bytes = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_CODEC_TAG;
    cfg_ch.data        = '0;
  end

  always @(posedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= out_idle);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input logic [63:0] s);
    bit taken;
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_bytes <= s;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // registers change only with the pipeline drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    bit taken;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_format(input logic [15:0] codec, input logic [15:0] bps);
    write_reg(REG_CODEC_TAG, codec);
    write_reg(REG_BPS, bps);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly ordinary audio levels, with some overrange, zero, NaN and infinity
  function automatic logic [63:0] pick_sample(input logic [15:0] codec, input logic [15:0] bps);
    logic [63:0] s;
    int          sel;
    s   = rand64();
    sel = $urandom_range(99);
    if (codec == CODEC_FLOAT && bps == 16'd32) begin
      if (sel < 70)      s[30:23] = 8'($urandom_range(100, 127));
      else if (sel < 80) s[30:23] = 8'($urandom_range(128, 140));
      else if (sel < 87) s[30:23] = 8'hff;
      else if (sel < 93) s[30:0]  = '0;
    end else if (codec == CODEC_FLOAT && bps == 16'd64) begin
      if (sel < 70)      s[62:52] = 11'($urandom_range(1000, 1023));
      else if (sel < 80) s[62:52] = 11'($urandom_range(1024, 1040));
      else if (sel < 87) s[62:52] = 11'h7ff;
      else if (sel < 93) s[62:0]  = '0;
    end
    return s;
  endfunction

  logic [15:0] fmt_codec [12] = '{CODEC_PCM, CODEC_PCM, CODEC_PCM, CODEC_PCM,
                                  CODEC_FLOAT, CODEC_FLOAT, CODEC_PCM, CODEC_FLOAT,
                                  16'd0, 16'd2, 16'hffff, CODEC_FLOAT};
  logic [15:0] fmt_bps   [12] = '{16'd8, 16'd16, 16'd24, 16'd32, 16'd32, 16'd64,
                                  16'd0, 16'd16, 16'd16, 16'd32, 16'd127, 16'd127};

  initial begin
    int k;
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset format first, then each codec with its edge values
    send_sample(64'h0);
    send_sample(64'hffff_ffff_ffff_ffff);
    send_sample(64'h1234_5678_9abc_8000);
    set_format(CODEC_PCM, 16'd8);
    send_sample(64'hffff_ffff_ffff_ff00);
    send_sample(64'h80);
    send_sample(64'hff);
    set_format(CODEC_PCM, 16'd24);
    send_sample(64'hffff_ffff_ff80_0000);
    set_format(CODEC_PCM, 16'd32);
    send_sample(64'h0000_0000_7fff_ffff);
    set_format(CODEC_FLOAT, 16'd32);
    send_sample(64'hffff_ffff_3f80_0000);
    send_sample(64'h0000_0000_bf80_0000);
    send_sample(64'h0000_0000_7fc0_0000);
    send_sample(64'h0000_0000_ff80_0000);
    send_sample(64'h0000_0000_0000_0001);
    send_sample(64'h0000_0000_c2c8_0000);
    set_format(CODEC_FLOAT, 16'd64);
    send_sample(64'h3ff0_0000_0000_0000);
    send_sample(64'hc000_0000_0000_0000);
    send_sample(64'h7ff0_0000_0000_0000);
    send_sample(64'h8000_0000_0000_0000);
    send_sample(64'h3fe0_0000_0000_0000);
    set_format(16'hffff, 16'd127);
    send_sample(64'hffff_ffff_ffff_ffff);
    set_format(CODEC_FLOAT, 16'd0);
    send_sample(64'h3ff0_0000_0000_0000);

    for (phase = 0; phase < 3; phase++) begin
      in_idle  = (phase == 0) ? 22 : (phase == 1) ? 86 : 0;
      out_idle = (phase == 0) ? 86 : (phase == 1) ? 22 : 0;
      for (k = 0; k < 20; k++) begin
        int f;
        int n;
        f = (k < 12) ? k : $urandom_range(5);
        set_format(fmt_codec[f], fmt_bps[f]);
        n = (f < 6) ? 26 : 8;
        repeat (n) send_sample(pick_sample(fmt_codec[f], fmt_bps[f]));
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
